/* src/thop_pkg.sv */
// shared types and constants of the tcp header and option parser
package thop_pkg;

   // record kinds on the result channel
   localparam logic [2:0] REC_HEADER     = 3'd0;
   localparam logic [2:0] REC_OPT_WORD   = 3'd1;
   localparam logic [2:0] REC_OPT_EMPTY  = 3'd2;
   localparam logic [2:0] REC_END_OK     = 3'd3;
   localparam logic [2:0] REC_END_BADOPT = 3'd4;
   localparam logic [2:0] REC_END_SHORT  = 3'd5;

   // fixed header layout, byte indexes
   localparam int unsigned IDX_SEQ      = 4;
   localparam int unsigned IDX_ACK      = 8;
   localparam int unsigned IDX_OFFSET   = 12;
   localparam int unsigned IDX_FLAGS    = 13;
   localparam int unsigned IDX_WIN_HI   = 14;
   localparam int unsigned IDX_WIN_LO   = 15;
   localparam int unsigned IDX_URG_HI   = 18;
   localparam int unsigned IDX_URG_LO   = 19;
   localparam int unsigned FIXED_HDR    = 20;

   // option kinds that are one byte long
   localparam logic [7:0] OPT_EOL = 8'd0;
   localparam logic [7:0] OPT_NOP = 8'd1;

   // result queue
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_BITS   = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [2:0]  record_kind;
      logic [31:0] ports;
      logic [31:0] seq_no;
      logic [31:0] ack_no;
      logic [5:0]  header_length;
      logic [5:0]  flags;
      logic [31:0] window_urgent;
      logic [7:0]  option_kind;
      logic [7:0]  option_length;
      logic [31:0] option_word;
      logic [15:0] payload_length;
      logic        last_in_run;
   } rec_type;

   // up to two records per byte: a header or option record, then an end record
   typedef struct packed {
      logic    first_valid;
      rec_type first;
      logic    fin_valid;
      rec_type fin;
   } push_type;

endpackage

/* src/thop_in_reg.sv */
// input register stage of the tcp header and option parser
module thop_in_reg
   import thop_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       req_stall,
   input  logic       take,
   output logic       in_valid,
   output logic [7:0] in_byte,
   output logic       in_last
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       load;

   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;
   assign in_last  = last_ff;

endmodule

/* src/thop_parse.sv */
// header field capture, option walk and record building, one byte per cycle while take is high
module thop_parse
   import thop_pkg::*;
#(
   parameter int COUNT_BITS = 16
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output push_type   push
);

   logic [COUNT_BITS-1:0] byte_count_ff, byte_count_in;
   logic [5:0]            hdr_len_ff, hdr_len_in;
   logic [31:0]           ports_ff, ports_in;
   logic [31:0]           seq_ff, seq_in;
   logic [31:0]           ack_ff, ack_in;
   logic [5:0]            flags_ff, flags_in;
   logic [31:0]           win_urg_ff, win_urg_in;
   logic [7:0]            opt_pos_ff, opt_pos_in;
   logic [7:0]            opt_kind_ff, opt_kind_in;
   logic [7:0]            opt_len_ff, opt_len_in;
   logic [31:0]           word_acc_ff, word_acc_in;
   logic                  bad_option_ff, bad_option_in;

   logic [COUNT_BITS-1:0] i;
   logic [COUNT_BITS:0]   i_plus1, reach, hdr_ext;
   logic [COUNT_BITS-1:0] hdr_cnt_nxt, total, pay_full;
   logic [31:0]           pay32;
   logic [15:0]           pay16;
   logic [8:0]            pos_plus1;
   logic                  opt_end, opt_active, short_seg;
   logic                  f_valid;
   logic [2:0]            f_kind;
   logic [7:0]            f_okind, f_olen;
   logic [31:0]           f_word;
   logic [5:0]            hdr_len_nxt;
   logic                  bad_nxt;

   assign i         = byte_count_ff;
   assign i_plus1   = {1'b0, i} + (COUNT_BITS+1)'(1);
   assign reach     = {1'b0, i} - (COUNT_BITS+1)'(1) + (COUNT_BITS+1)'(in_byte);
   assign hdr_ext   = (COUNT_BITS+1)'(hdr_len_ff);
   assign pos_plus1 = {1'b0, opt_pos_ff} + 9'd1;
   assign opt_end   = (pos_plus1 == {1'b0, opt_len_ff});
   assign opt_active = (i >= COUNT_BITS'(FIXED_HDR)) && ({1'b0, i} < hdr_ext)
                       && !bad_option_ff;

   always_comb begin
      hdr_len_nxt = hdr_len_ff;
      ports_in    = ports_ff;
      seq_in      = seq_ff;
      ack_in      = ack_ff;
      flags_in    = flags_ff;
      win_urg_in  = win_urg_ff;
      opt_pos_in  = opt_pos_ff;
      opt_kind_in = opt_kind_ff;
      opt_len_in  = opt_len_ff;
      word_acc_in = word_acc_ff;
      bad_nxt     = bad_option_ff;
      f_valid     = 1'b0;
      f_kind      = REC_HEADER;
      f_okind     = 8'd0;
      f_olen      = 8'd0;
      f_word      = 32'd0;

      if (i < COUNT_BITS'(IDX_SEQ)) begin
         ports_in = {ports_ff[23:0], in_byte};
      end else if (i < COUNT_BITS'(IDX_ACK)) begin
         seq_in = {seq_ff[23:0], in_byte};
      end else if (i < COUNT_BITS'(IDX_OFFSET)) begin
         ack_in = {ack_ff[23:0], in_byte};
      end else if (i == COUNT_BITS'(IDX_OFFSET)) begin
         hdr_len_nxt = {in_byte[7:4], 2'b00};
      end else if (i == COUNT_BITS'(IDX_FLAGS)) begin
         flags_in = in_byte[5:0];
      end else if (i == COUNT_BITS'(IDX_WIN_HI) || i == COUNT_BITS'(IDX_WIN_LO) ||
                   i == COUNT_BITS'(IDX_URG_HI) || i == COUNT_BITS'(IDX_URG_LO)) begin
         win_urg_in = {win_urg_ff[23:0], in_byte};
      end else if (opt_active) begin
         if (opt_pos_ff == 8'd0) begin
            // kind byte
            opt_kind_in = in_byte;
            word_acc_in = 32'd0;
            if (in_byte == OPT_EOL || in_byte == OPT_NOP) begin
               opt_len_in = 8'd1;
               f_valid    = 1'b1;
               f_kind     = REC_OPT_EMPTY;
               f_okind    = in_byte;
               f_olen     = 8'd1;
            end else if (i_plus1 >= hdr_ext) begin
               bad_nxt = 1'b1;
            end else begin
               opt_pos_in = 8'd1;
            end
         end else if (opt_pos_ff == 8'd1) begin
            // length byte
            if (in_byte < 8'd2 || reach > hdr_ext) begin
               bad_nxt    = 1'b1;
               opt_pos_in = 8'd0;
            end else begin
               opt_len_in = in_byte;
               if (in_byte == 8'd2) begin
                  f_valid    = 1'b1;
                  f_kind     = REC_OPT_EMPTY;
                  f_okind    = opt_kind_ff;
                  f_olen     = 8'd2;
                  opt_pos_in = 8'd0;
               end else begin
                  opt_pos_in = 8'd2;
               end
            end
         end else begin
            // value bytes, a word closes at every fourth byte or at the option end
            word_acc_in = {word_acc_ff[23:0], in_byte};
            if (opt_end || opt_pos_ff[1:0] == 2'd1) begin
               f_valid     = 1'b1;
               f_kind      = REC_OPT_WORD;
               f_okind     = opt_kind_ff;
               f_olen      = opt_len_ff;
               f_word      = {word_acc_ff[23:0], in_byte};
               word_acc_in = 32'd0;
            end
            opt_pos_in = opt_end ? 8'd0 : pos_plus1[7:0];
         end
      end

      if (i == COUNT_BITS'(IDX_URG_LO)) begin
         f_valid = 1'b1;
         f_kind  = REC_HEADER;
      end
   end

   // count after this byte, saturating
   assign total       = (&i) ? i : i_plus1[COUNT_BITS-1:0];
   assign hdr_cnt_nxt = COUNT_BITS'(hdr_len_nxt);
   assign short_seg   = (total < COUNT_BITS'(FIXED_HDR)) || (total < hdr_cnt_nxt);
   assign pay_full    = total - hdr_cnt_nxt;
   assign pay32       = 32'(pay_full);
   assign pay16       = (|pay32[31:16]) ? 16'hFFFF : pay32[15:0];

   always_comb begin
      push.first_valid               = take && f_valid;
      push.first.record_kind         = f_kind;
      push.first.ports               = ports_in;
      push.first.seq_no              = seq_in;
      push.first.ack_no              = ack_in;
      push.first.header_length       = hdr_len_nxt;
      push.first.flags               = flags_in;
      push.first.window_urgent       = win_urg_in;
      push.first.option_kind         = f_okind;
      push.first.option_length       = f_olen;
      push.first.option_word         = f_word;
      push.first.payload_length      = 16'd0;
      push.first.last_in_run         = !in_last;

      push.fin_valid                 = take && in_last;
      push.fin.record_kind           = short_seg ? REC_END_SHORT :
                                       (bad_nxt ? REC_END_BADOPT : REC_END_OK);
      push.fin.ports                 = ports_in;
      push.fin.seq_no                = seq_in;
      push.fin.ack_no                = ack_in;
      push.fin.header_length         = hdr_len_nxt;
      push.fin.flags                 = flags_in;
      push.fin.window_urgent         = win_urg_in;
      push.fin.option_kind           = 8'd0;
      push.fin.option_length         = 8'd0;
      push.fin.option_word           = 32'd0;
      push.fin.payload_length        = short_seg ? 16'd0 : pay16;
      push.fin.last_in_run           = 1'b1;
   end

   // the end of a segment returns every register to its reset value
   assign byte_count_in = in_last ? '0 : total;
   assign hdr_len_in    = in_last ? 6'd0 : hdr_len_nxt;
   assign bad_option_in = in_last ? 1'b0 : bad_nxt;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         hdr_len_ff    <= 6'd0;
         ports_ff      <= 32'd0;
         seq_ff        <= 32'd0;
         ack_ff        <= 32'd0;
         flags_ff      <= 6'd0;
         win_urg_ff    <= 32'd0;
         opt_pos_ff    <= 8'd0;
         opt_kind_ff   <= 8'd0;
         opt_len_ff    <= 8'd0;
         word_acc_ff   <= 32'd0;
         bad_option_ff <= 1'b0;
      end else if (take) begin
         byte_count_ff <= byte_count_in;
         hdr_len_ff    <= hdr_len_in;
         bad_option_ff <= bad_option_in;
         ports_ff      <= in_last ? 32'd0 : ports_in;
         seq_ff        <= in_last ? 32'd0 : seq_in;
         ack_ff        <= in_last ? 32'd0 : ack_in;
         flags_ff      <= in_last ? 6'd0 : flags_in;
         win_urg_ff    <= in_last ? 32'd0 : win_urg_in;
         opt_pos_ff    <= in_last ? 8'd0 : opt_pos_in;
         opt_kind_ff   <= in_last ? 8'd0 : opt_kind_in;
         opt_len_ff    <= in_last ? 8'd0 : opt_len_in;
         word_acc_ff   <= in_last ? 32'd0 : word_acc_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      take && in_last |=> byte_count_ff == '0 && !bad_option_ff)
      else $error("segment state not cleared after final beat");

   a_bad_only_in_options: assert property (@(posedge clock) disable iff (reset)
      $rose(bad_option_ff) |-> $past(take) && $past(i) >= COUNT_BITS'(FIXED_HDR))
      else $error("bad option flagged outside the option area");
`endif

endmodule

/* src/thop_rsp_fifo.sv */
// small result queue, up to two records in and one record out per cycle while the receiver does not stall
module thop_rsp_fifo
   import thop_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rec_type  head
);

   rec_type             mem_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [1:0]          push_n;
   logic                pop;
   rec_type             w0;

   assign push_n = {1'b0, push.first_valid} + {1'b0, push.fin_valid};
   assign w0     = push.first_valid ? push.first : push.fin;
   assign pop    = rsp_valid && !rsp_stall;

   assign wr_in    = wr_ff + PTR_BITS'(push_n);
   assign rd_in    = rd_ff + PTR_BITS'(pop);
   assign count_in = count_ff + CNT_BITS'(push_n) - CNT_BITS'(pop);

   // room for two records, independent of the receiver this cycle
   assign room      = (count_ff <= CNT_BITS'(FIFO_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign head      = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ff] <= w0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ff + PTR_BITS'(1)] <= push.fin;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(FIFO_DEPTH))
      else $error("result queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_n != 2'd0 |-> 32'(count_ff) + 32'(push_n) <= 32'(FIFO_DEPTH))
      else $error("result queue written while full");
`endif

endmodule

/* src/tcp_header_option_parser.sv */
// top level of the tcp header and option parser
//
// Bytes of a segment enter on the req_ channel, header first, one beat per
// byte, with req_last_byte set on the final byte. Records leave on the rsp_
// channel: a header record after header byte 19, one record per option value
// word or per option without words, and an end record with the payload length
// and a status after the final byte. rsp_last_in_run marks the last record
// that one byte produced.
// An accepted byte passes the input register and the result queue before
// its first record shows on rsp_. Throughput is one byte per cycle while the
// receiver keeps up; a byte that yields two records (header or option record
// plus end record) writes both into the four-entry result queue at once,
// and req_stall rises only when that queue holds more than two records.
// A stalled record stays on the rsp_ ports unchanged until taken.
// Reset clears the parse state and empties the queue; the block is ready for
// a new segment in the cycle after reset falls and after every final byte.
module tcp_header_option_parser
   import thop_pkg::*;
#(
   parameter int COUNT_BITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_record_kind,
   output logic [31:0] rsp_ports,
   output logic [31:0] rsp_seq_no,
   output logic [31:0] rsp_ack_no,
   output logic [5:0]  rsp_header_length,
   output logic [5:0]  rsp_flags,
   output logic [31:0] rsp_window_urgent,
   output logic [7:0]  rsp_option_kind,
   output logic [7:0]  rsp_option_length,
   output logic [31:0] rsp_option_word,
   output logic [15:0] rsp_payload_length,
   output logic        rsp_last_in_run
);

   logic       in_valid, in_last, room, take;
   logic [7:0] in_byte;
   push_type   push;
   rec_type    head;

   assign take = in_valid && room;

   thop_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .req_stall     (req_stall),
      .take          (take),
      .in_valid      (in_valid),
      .in_byte       (in_byte),
      .in_last       (in_last)
   );

   thop_parse #(
      .COUNT_BITS (COUNT_BITS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .in_byte (in_byte),
      .in_last (in_last),
      .push    (push)
   );

   thop_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_record_kind    = head.record_kind;
   assign rsp_ports          = head.ports;
   assign rsp_seq_no         = head.seq_no;
   assign rsp_ack_no         = head.ack_no;
   assign rsp_header_length  = head.header_length;
   assign rsp_flags          = head.flags;
   assign rsp_window_urgent  = head.window_urgent;
   assign rsp_option_kind    = head.option_kind;
   assign rsp_option_length  = head.option_length;
   assign rsp_option_word    = head.option_word;
   assign rsp_payload_length = head.payload_length;
   assign rsp_last_in_run    = head.last_in_run;

endmodule

/* tb/tcp_header_option_parser_tb.sv */
// testbench of the tcp header and option parser: byte stream in, records out
`timescale 1ns / 100ps

module tcp_header_option_parser_tb
   import thop_pkg::*;
();

   localparam int COUNT_BITS = 16;
   localparam int IDLE_PCT   = 36;
   localparam int HOLD_BEATS = 300;
   localparam int MAX_PRINTS = 100;

   // how a header is filled
   localparam int FILL_RANDOM = 0;
   localparam int FILL_ONES   = 1;
   localparam int FILL_ZEROS  = 2;

   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
   } octet_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_record_kind;
   logic [31:0] rsp_ports;
   logic [31:0] rsp_seq_no;
   logic [31:0] rsp_ack_no;
   logic [5:0]  rsp_header_length;
   logic [5:0]  rsp_flags;
   logic [31:0] rsp_window_urgent;
   logic [7:0]  rsp_option_kind;
   logic [7:0]  rsp_option_length;
   logic [31:0] rsp_option_word;
   logic [15:0] rsp_payload_length;
   logic        rsp_last_in_run;

   octet_type byte_queue[$];
   rec_type   expected_records[$];
   int        errors = 0;
   logic      calm = 1'b0;
   logic      hold_go = 1'b0;
   logic      hold_done = 1'b0;
   int        hold_left = 0;

   // parser state as the predictor sees it
   logic [COUNT_BITS-1:0] seen_count = '0;
   logic [5:0]  hdr_len = '0;
   logic [31:0] ports_acc = '0;
   logic [31:0] seq_acc = '0;
   logic [31:0] ack_acc = '0;
   logic [5:0]  flag_bits = '0;
   logic [31:0] win_urg_acc = '0;
   logic [7:0]  opt_pos = '0;
   logic [7:0]  opt_kind = '0;
   logic [7:0]  opt_len = '0;
   logic [31:0] word_acc = '0;
   logic        bad_opt = 1'b0;

   tcp_header_option_parser #(.COUNT_BITS(COUNT_BITS)) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_record_kind    (rsp_record_kind),
      .rsp_ports          (rsp_ports),
      .rsp_seq_no         (rsp_seq_no),
      .rsp_ack_no         (rsp_ack_no),
      .rsp_header_length  (rsp_header_length),
      .rsp_flags          (rsp_flags),
      .rsp_window_urgent  (rsp_window_urgent),
      .rsp_option_kind    (rsp_option_kind),
      .rsp_option_length  (rsp_option_length),
      .rsp_option_word    (rsp_option_word),
      .rsp_payload_length (rsp_payload_length),
      .rsp_last_in_run    (rsp_last_in_run)
   );

   always #10 clock = ~clock;

   task automatic report_error(input string msg);
      errors++;
      if (errors <= MAX_PRINTS) begin
         $display("%0t ns: mismatch: %s", $time, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_error($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   task automatic clear_parse_state();
      seen_count = '0;
      hdr_len = '0;
      ports_acc = '0;
      seq_acc = '0;
      ack_acc = '0;
      flag_bits = '0;
      win_urg_acc = '0;
      opt_pos = '0;
      opt_kind = '0;
      opt_len = '0;
      word_acc = '0;
      bad_opt = 1'b0;
   endtask

   function automatic rec_type make_rec(input logic [2:0] kind, input logic [7:0] okind,
                                        input logic [7:0] olen, input logic [31:0] word,
                                        input logic [15:0] pay);
      rec_type r;
      r.record_kind    = kind;
      r.ports          = ports_acc;
      r.seq_no         = seq_acc;
      r.ack_no         = ack_acc;
      r.header_length  = hdr_len;
      r.flags          = flag_bits;
      r.window_urgent  = win_urg_acc;
      r.option_kind    = okind;
      r.option_length  = olen;
      r.option_word    = word;
      r.payload_length = pay;
      r.last_in_run    = 1'b0;
      return r;
   endfunction

   // advance the parser by one byte and queue the records it yields
   task automatic parse_byte(input logic [7:0] b, input logic is_last);
      rec_type     recs[$];
      int unsigned i;
      int unsigned hl;
      int unsigned total;
      logic [7:0]  word_idx;
      logic        opt_end;
      i  = seen_count;
      hl = hdr_len;
      if (i < IDX_SEQ) begin
         ports_acc = {ports_acc[23:0], b};
      end else if (i < IDX_ACK) begin
         seq_acc = {seq_acc[23:0], b};
      end else if (i < IDX_OFFSET) begin
         ack_acc = {ack_acc[23:0], b};
      end else if (i == IDX_OFFSET) begin
         hdr_len = {b[7:4], 2'b00};
      end else if (i == IDX_FLAGS) begin
         flag_bits = b[5:0];
      end else if (i == IDX_WIN_HI || i == IDX_WIN_LO || i == IDX_URG_HI || i == IDX_URG_LO) begin
         win_urg_acc = {win_urg_acc[23:0], b};
      end else if (i >= FIXED_HDR && i < hl && !bad_opt) begin
         if (opt_pos == 8'd0) begin
            opt_kind = b;
            word_acc = '0;
            if (b == OPT_EOL || b == OPT_NOP) begin
               opt_len = 8'd1;
               recs.push_back(make_rec(REC_OPT_EMPTY, b, 8'd1, '0, '0));
            end else if (i + 1 >= hl) begin
               bad_opt = 1'b1;
            end else begin
               opt_pos = 8'd1;
            end
         end else if (opt_pos == 8'd1) begin
            if (b < 8'd2 || (i - 1) + b > hl) begin
               bad_opt = 1'b1;
               opt_pos = 8'd0;
            end else begin
               opt_len = b;
               if (b == 8'd2) begin
                  recs.push_back(make_rec(REC_OPT_EMPTY, opt_kind, 8'd2, '0, '0));
                  opt_pos = 8'd0;
               end else begin
                  opt_pos = 8'd2;
               end
            end
         end else begin
            opt_end  = (int'(opt_pos) + 1 == int'(opt_len));
            word_idx = opt_pos - 8'd2;
            word_acc = {word_acc[23:0], b};
            // a word closes on its fourth byte or at the option end
            if (opt_end || word_idx[1:0] == 2'b11) begin
               recs.push_back(make_rec(REC_OPT_WORD, opt_kind, opt_len, word_acc, '0));
               word_acc = '0;
            end
            opt_pos = opt_end ? 8'd0 : opt_pos + 8'd1;
         end
      end
      if (i == IDX_URG_LO) begin
         recs.push_back(make_rec(REC_HEADER, '0, '0, '0, '0));
      end
      if (seen_count != '1) begin
         seen_count++;
      end
      if (is_last) begin
         total = seen_count;
         if (total < FIXED_HDR || total < hdr_len) begin
            recs.push_back(make_rec(REC_END_SHORT, '0, '0, '0, '0));
         end else begin
            recs.push_back(make_rec(bad_opt ? REC_END_BADOPT : REC_END_OK, '0, '0, '0,
                                    16'(total - hdr_len)));
         end
         clear_parse_state();
      end
      if (recs.size() > 0) begin
         recs[recs.size()-1].last_in_run = 1'b1;
      end
      foreach (recs[k]) begin
         expected_records.push_back(recs[k]);
      end
   endtask

   // sender
   always @(posedge clock) begin
      octet_type item;
      if (reset) begin
         req_valid <= 1'b0;
         clear_parse_state();
      end else begin
         if (req_valid && !req_stall) begin
            parse_byte(req_data_byte, req_last_byte);
         end
         if (!req_valid || !req_stall) begin
            if (byte_queue.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               item = byte_queue.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= item.data;
               req_last_byte <= item.is_last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_BEATS;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // result checker
   always @(posedge clock) begin
      rec_type got;
      rec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.record_kind    = rsp_record_kind;
         got.ports          = rsp_ports;
         got.seq_no         = rsp_seq_no;
         got.ack_no         = rsp_ack_no;
         got.header_length  = rsp_header_length;
         got.flags          = rsp_flags;
         got.window_urgent  = rsp_window_urgent;
         got.option_kind    = rsp_option_kind;
         got.option_length  = rsp_option_length;
         got.option_word    = rsp_option_word;
         got.payload_length = rsp_payload_length;
         got.last_in_run    = rsp_last_in_run;
         if (expected_records.size() == 0) begin
            report_error($sformatf("unexpected record of kind %0d", got.record_kind));
         end else begin
            want = expected_records.pop_front();
            check_field("record_kind", got.record_kind, want.record_kind);
            check_field("ports", got.ports, want.ports);
            check_field("seq_no", got.seq_no, want.seq_no);
            check_field("ack_no", got.ack_no, want.ack_no);
            check_field("header_length", got.header_length, want.header_length);
            check_field("flags", got.flags, want.flags);
            check_field("window_urgent", got.window_urgent, want.window_urgent);
            check_field("option_kind", got.option_kind, want.option_kind);
            check_field("option_length", got.option_length, want.option_length);
            check_field("option_word", got.option_word, want.option_word);
            check_field("payload_length", got.payload_length, want.payload_length);
            check_field("last_in_run", got.last_in_run, want.last_in_run);
         end
      end
   end

   task automatic put_fixed_header(ref logic [7:0] seg[$], input logic [3:0] nib,
                                   input int fill);
      logic [7:0] v;
      for (int k = 0; k < FIXED_HDR; k++) begin
         case (fill)
            FILL_ONES:  v = 8'hFF;
            FILL_ZEROS: v = 8'h00;
            default:    v = 8'($urandom);
         endcase
         if (k == IDX_OFFSET) begin
            v = {nib, v[3:0]};
         end
         seg.push_back(v);
      end
   endtask

   task automatic put_bytes(ref logic [7:0] seg[$], input int n);
      repeat (n) seg.push_back(8'($urandom));
   endtask

   task automatic put_option(ref logic [7:0] seg[$], input logic [7:0] kind,
                             input int len);
      seg.push_back(kind);
      seg.push_back(len[7:0]);
      if (len > 2) begin
         put_bytes(seg, len - 2);
      end
   endtask

   // well-formed options that fill the option area exactly
   task automatic put_options(ref logic [7:0] seg[$], input int room);
      int len;
      while (room > 0) begin
         if (room == 1 || $urandom_range(0, 3) == 0) begin
            seg.push_back($urandom_range(0, 1) ? OPT_NOP : OPT_EOL);
            room--;
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               len = $urandom_range(2, room);
            end else begin
               len = $urandom_range(2, room < 12 ? room : 12);
            end
            put_option(seg, 8'($urandom_range(2, 255)), len);
            room -= len;
         end
      end
   endtask

   task automatic send_segment(ref logic [7:0] seg[$]);
      octet_type item;
      foreach (seg[k]) begin
         item.data    = seg[k];
         item.is_last = (k == seg.size() - 1);
         byte_queue.push_back(item);
      end
      seg.delete();
   endtask

   // mostly well-formed segments, the rest corrupted, truncated, with a data offset below the fixed header, or noise
   task automatic random_segments(input int target);
      logic [7:0] seg[$];
      int sent;
      int mode;
      int nib;
      int cut;
      sent = 0;
      while (sent < target) begin
         mode = $urandom_range(0, 99);
         nib  = (mode >= 78 && mode < 86) ? $urandom_range(0, 4) : $urandom_range(5, 15);
         if (mode >= 86) begin
            put_bytes(seg, $urandom_range(1, 80));
         end else begin
            put_fixed_header(seg, 4'(nib), FILL_RANDOM);
            if (nib >= 5) begin
               put_options(seg, nib * 4 - FIXED_HDR);
            end
            put_bytes(seg, $urandom_range(0, 20));
            if (mode >= 60 && mode < 70 && nib > 5) begin
               seg[$urandom_range(FIXED_HDR, nib * 4 - 1)] = 8'($urandom);
            end
            if (mode >= 70 && mode < 78) begin
               cut = $urandom_range(1, seg.size() - 1);
               while (seg.size() > cut) void'(seg.pop_back());
            end
         end
         sent += seg.size();
         send_segment(seg);
      end
   endtask

   task automatic wait_drained();
      while (byte_queue.size() != 0 || req_valid || expected_records.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      logic [7:0] seg[$];
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // bare header whose last byte ends the segment
      put_fixed_header(seg, 4'd5, FILL_ZEROS);
      send_segment(seg);
      // all-ones header, full option area with every option shape
      put_fixed_header(seg, 4'd15, FILL_ONES);
      seg.push_back(OPT_NOP);
      seg.push_back(OPT_EOL);
      put_option(seg, 8'd2, 4);
      put_option(seg, 8'd3, 3);
      put_option(seg, 8'd4, 2);
      put_option(seg, 8'd8, 10);
      put_option(seg, 8'd5, 11);
      put_option(seg, 8'd254, 8);
      put_bytes(seg, 3);
      send_segment(seg);
      // option length of one
      put_fixed_header(seg, 4'd8, FILL_RANDOM);
      seg.push_back(OPT_NOP);
      put_option(seg, 8'd5, 1);
      put_bytes(seg, 11);
      send_segment(seg);
      // option length of zero
      put_fixed_header(seg, 4'd7, FILL_RANDOM);
      put_option(seg, 8'd30, 0);
      put_bytes(seg, 6);
      send_segment(seg);
      // option length beyond the header end
      put_fixed_header(seg, 4'd6, FILL_RANDOM);
      put_option(seg, 8'd2, 6);
      put_bytes(seg, 4);
      send_segment(seg);
      // option kind on the last header byte
      put_fixed_header(seg, 4'd6, FILL_RANDOM);
      seg = {seg, OPT_NOP, OPT_NOP, OPT_NOP, 8'd7, 8'hA5};
      send_segment(seg);
      // short segments: one byte, 19 bytes, fewer bytes than the data offset
      put_bytes(seg, 1);
      send_segment(seg);
      put_fixed_header(seg, 4'd5, FILL_ONES);
      void'(seg.pop_back());
      send_segment(seg);
      put_fixed_header(seg, 4'd10, FILL_RANDOM);
      put_bytes(seg, 10);
      send_segment(seg);
      // bad option inside a short segment
      put_fixed_header(seg, 4'd8, FILL_RANDOM);
      put_option(seg, 8'd9, 1);
      put_bytes(seg, 3);
      send_segment(seg);
      // data offset below the fixed header
      put_fixed_header(seg, 4'd2, FILL_RANDOM);
      put_bytes(seg, 5);
      send_segment(seg);
      put_fixed_header(seg, 4'd0, FILL_RANDOM);
      send_segment(seg);
      wait_drained();

      random_segments(12);
      wait_drained();

      // a stretch with no idling on either side
      calm = 1'b1;
      random_segments(24);
      wait_drained();
      calm = 1'b0;

      // receiver holds off while the sender keeps offering an option-rich segment
      hold_go = 1'b1;
      put_fixed_header(seg, 4'd12, FILL_RANDOM);
      put_options(seg, 28);
      put_bytes(seg, 4);
      send_segment(seg);
      wait_drained();

      repeat (10) @(posedge clock);
      if (expected_records.size() != 0) begin
         report_error($sformatf("%0d records never arrived", expected_records.size()));
      end
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
